// ===== src/rmf_pkg.sv =====
package rmf_pkg;

    // default sizes of the window store and of one sample
    localparam int DEF_MAX_WINDOW  = 15;
    localparam int DEF_SAMPLE_BITS = 32;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int WS_W       = 4;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

    localparam logic [WS_W-1:0] WINDOW_SIZE_RESET = 4'd5;

    // flags that travel beside each output word
    typedef struct packed {
        logic is_median;
        logic last_out;
    } out_flags_t;

endpackage

// ===== src/rmf_median.sv =====
// rank-based median of the newest 2h+1 window taps
// every tap counts the members ranked below it (ties broken by tap position),
// the tap whose rank equals h is the median
module rmf_median
    import rmf_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int CNT_W       = $clog2(MAX_WINDOW + 1)
)
(
    input  logic signed [SAMPLE_BITS-1:0] taps [MAX_WINDOW],
    input  logic        [CNT_W-1:0]       half,
    output logic signed [SAMPLE_BITS-1:0] median
);

    logic [MAX_WINDOW-1:0] member;
    logic [MAX_WINDOW-1:0] below [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] pick;

    // window membership: taps 0 .. 2h
    always_comb
    begin
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            member[j] = (j <= 2 * int'(half));
        end
    end

    // pairwise order of all member taps
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            for (int j = 0; j < MAX_WINDOW; j++)
            begin
                below[i][j] = member[j] && (j != i) &&
                              ((taps[j] < taps[i]) || ((taps[j] == taps[i]) && (j < i)));
            end
        end
    end

    // rank compare and one-hot select
    always_comb
    begin
        median = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            pick[i] = member[i] && ($countones(below[i]) == int'(half));
            if (pick[i])
            begin
                median = median | taps[i];
            end
        end
    end

endmodule

// ===== src/rmf_out_reg.sv =====
// output register of the stream: loads whenever empty or being drained
module rmf_out_reg
    import rmf_pkg::*;
#(
    parameter int DW = DEF_SAMPLE_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load_valid,
    output logic          load_ready,
    input  logic [DW-1:0] load_data,
    input  out_flags_t    load_flags,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [DW-1:0] m_tdata,   // smoothed, zero padded
    output logic          m_tuser,   // is_median
    output logic          m_tlast    // last_out
);

    logic          valid_reg;
    logic [DW-1:0] data_reg;
    out_flags_t    flags_reg;

    assign load_ready = !valid_reg || m_tready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= load_valid;
        end
    end

    // payload word
    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            data_reg  <= load_data;
            flags_reg <= load_flags;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = flags_reg.is_median;
    assign m_tlast  = flags_reg.last_out;

endmodule

// ===== src/running_median_filter_core.sv =====
// Running median filter over one streamed series of signed samples. The window
// is window_size raised to the next odd value w (capped at MAX_WINDOW), h = w/2.
// Output k is the median of inputs k-h..k+h and leaves when input k+h arrives;
// the first and last h samples pass through raw (tuser low). A word with tlast
// closes the series: its own result comes first, then the min(n,h) samples still
// held drain raw, oldest first, one word per clock while the output accepts, and
// the last output carries tlast. Throughput is one sample per clock while the
// output accepts; after a tlast sample the input stalls while the held samples
// drain, set by the single read port on the window shift register that feeds the
// output register. Each result is registered in the output register once its
// sample is in the window. window_size may be written over APB at address 0
// only while the filter holds no pending sample.
module running_median_filter_core
    import rmf_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_ADDR_W-1:0]         paddr,
    input  logic [CFG_DATA_W-1:0]         pwdata,
    output logic [CFG_DATA_W-1:0]         prdata,
    output logic                          pready,
    // sample input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,   // sample
    input  logic                          s_tlast,   // last_of_series
    // filtered output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,   // smoothed
    output logic                          m_tuser,   // is_median
    output logic                          m_tlast    // last_out
);

    localparam int TDW   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDXW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int HCAP  = (MAX_WINDOW - 1) / 2;

    logic [WS_W-1:0]               window_size_reg;
    logic signed [SAMPLE_BITS-1:0] window_reg [MAX_WINDOW];
    logic [CNT_W-1:0]              samples_seen_reg;
    logic [CNT_W-1:0]              samples_seen_next;
    logic                          pend_main_reg;
    logic                          pend_med_reg;
    logic                          pend_last_reg;
    logic [CNT_W-1:0]              flush_cnt_reg;

    logic [CNT_W-1:0]              half;
    logic                          cfg_write;
    logic                          s_acc;
    logic                          emit_valid;
    logic                          emit_final;
    logic                          emit_fire;
    logic                          out_ready;
    logic [IDXW-1:0]               rd_idx;
    logic signed [SAMPLE_BITS-1:0] raw_word;
    logic signed [SAMPLE_BITS-1:0] median;
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic [TDW-1:0]                out_data;
    out_flags_t                    out_flags;
    logic [CNT_W:0]                seen_ext;
    logic [CNT_W:0]                seen_plus;
    logic                          take_main;
    logic                          take_med;
    logic [CNT_W-1:0]              take_flush;

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            window_size_reg <= pwdata[WS_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_WINDOW_SIZE)
        begin
            prdata[WS_W-1:0] = window_size_reg;
        end
    end

    // half window, capped by the store depth
    always_comb
    begin
        if (int'(window_size_reg[WS_W-1:1]) > HCAP)
        begin
            half = CNT_W'(HCAP);
        end
        else
        begin
            half = CNT_W'(window_size_reg[WS_W-1:1]);
        end
    end

    // emission of the pending word: main result first, then the drain
    assign emit_valid = pend_main_reg || (flush_cnt_reg != '0);
    assign emit_final = pend_main_reg ? (flush_cnt_reg == '0)
                                      : (flush_cnt_reg == CNT_W'(1));
    assign emit_fire  = emit_valid && out_ready;
    assign s_tready   = !emit_valid || (emit_fire && emit_final);
    assign s_acc      = s_tvalid && s_tready;

    // what the accepted word will produce
    assign seen_ext  = {1'b0, samples_seen_reg};
    assign seen_plus = seen_ext + (CNT_W+1)'(1);
    assign take_main = seen_ext >= {1'b0, half};
    assign take_med  = seen_ext >= {half, 1'b0};

    always_comb
    begin
        take_flush = '0;
        if (s_tlast)
        begin
            if (seen_plus < {1'b0, half})
            begin
                take_flush = seen_plus[CNT_W-1:0];
            end
            else
            begin
                take_flush = half;
            end
        end
    end

    always_comb
    begin
        if (s_tlast)
        begin
            samples_seen_next = '0;
        end
        else if (samples_seen_reg == CNT_W'(MAX_WINDOW))
        begin
            samples_seen_next = samples_seen_reg;
        end
        else
        begin
            samples_seen_next = samples_seen_reg + CNT_W'(1);
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_seen_reg <= '0;
            pend_main_reg    <= 1'b0;
            pend_med_reg     <= 1'b0;
            pend_last_reg    <= 1'b0;
            flush_cnt_reg    <= '0;
        end
        else if (s_acc)
        begin
            samples_seen_reg <= samples_seen_next;
            pend_main_reg    <= take_main;
            pend_med_reg     <= take_med;
            pend_last_reg    <= s_tlast;
            flush_cnt_reg    <= take_flush;
        end
        else if (emit_fire)
        begin
            if (pend_main_reg)
            begin
                pend_main_reg <= 1'b0;
            end
            else
            begin
                flush_cnt_reg <= flush_cnt_reg - CNT_W'(1);
            end
        end
    end

    // window shift register, entry 0 newest
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            window_reg[0] <= s_tdata[SAMPLE_BITS-1:0];
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                window_reg[i] <= window_reg[i-1];
            end
        end
    end

    // raw tap read: tap h for the main word, else the next drain tap
    assign rd_idx   = pend_main_reg ? IDXW'(half) : IDXW'(flush_cnt_reg - CNT_W'(1));
    assign raw_word = window_reg[rd_idx];

    rmf_median #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_median (
        .taps   (window_reg),
        .half   (half),
        .median (median)
    );

    // result word
    assign smoothed            = (pend_main_reg && pend_med_reg) ? median : raw_word;
    assign out_data            = TDW'(unsigned'(smoothed));
    assign out_flags.is_median = pend_main_reg && pend_med_reg;
    assign out_flags.last_out  = pend_last_reg && emit_final;

    rmf_out_reg #(
        .DW (TDW)
    ) u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (emit_valid),
        .load_ready (out_ready),
        .load_data  (out_data),
        .load_flags (out_flags),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== verif/rmf_median_checker.sv =====
`timescale 1ns / 100ps

module rmf_median_checker
    import rmf_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [CFG_ADDR_W-1:0]            paddr,
    input  logic [CFG_DATA_W-1:0]            pwdata,
    input  logic                             pready,
    // sample input
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [((DEF_SAMPLE_BITS+7)/8)*8-1:0] s_tdata,   // sample
    input  logic                             s_tlast,   // last_of_series
    // filtered output
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [((DEF_SAMPLE_BITS+7)/8)*8-1:0] m_tdata,   // smoothed
    input  logic                             m_tuser,   // is_median
    input  logic                             m_tlast,   // last_out
    output int                               error_count,
    output int                               words_due
);

    localparam int MAXW = DEF_MAX_WINDOW;
    localparam int SW   = DEF_SAMPLE_BITS;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct packed {
        sample_t    smoothed;
        out_flags_t flags;
    } out_word_t;

    // own copy of the filter state
    sample_t           hist [MAXW];
    int unsigned       filled  = 0;
    logic [WS_W-1:0]   ws_cfg  = WINDOW_SIZE_RESET;
    out_word_t         awaited [$];
    int                errors  = 0;
    int                n_due   = 0;

    assign error_count = errors;
    assign words_due   = n_due;

    // window length after rounding up to odd and capping at the store depth
    function automatic int unsigned eff_width(input logic [WS_W-1:0] ws);
        int unsigned w;
        int unsigned cap;
        w   = 2 * (ws / 2) + 1;
        cap = (MAXW % 2 == 1) ? MAXW : MAXW - 1;
        return (w > cap) ? cap : w;
    endfunction

    // middle value of the newest w samples in signed order
    function automatic sample_t mid_value(input int unsigned w);
        sample_t sorted [MAXW];
        sample_t v;
        int      j;
        for (int i = 0; i < w; i++)
        begin
            v = hist[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[w / 2];
    endfunction

    function automatic out_word_t make_word(input sample_t value, input logic med);
        out_word_t o;
        o.smoothed        = value;
        o.flags.is_median = med;
        o.flags.last_out  = 1'b0;
        return o;
    endfunction

    // work out the words caused by one accepted sample
    task automatic take_sample(input sample_t value, input logic last);
        out_word_t   res [MAXW + 1];
        int unsigned w;
        int unsigned h;
        int unsigned t;
        int unsigned drain;
        int          k;
        w = eff_width(ws_cfg);
        h = w / 2;
        t = filled;
        k = 0;
        for (int i = MAXW - 1; i > 0; i--)
            hist[i] = hist[i-1];
        hist[0] = value;

        // median once the window is full, raw sample while the head fills
        if (t >= 2 * h)
        begin
            res[k] = make_word(mid_value(w), 1'b1);
            k++;
        end
        else if (t >= h)
        begin
            res[k] = make_word(hist[h], 1'b0);
            k++;
        end

        if (!last)
        begin
            if (filled < MAXW)
                filled++;
        end
        else
        begin
            // tail drains raw, oldest first
            drain = (t + 1 < h) ? t + 1 : h;
            for (int i = drain; i > 0; i--)
            begin
                res[k] = make_word(hist[i-1], 1'b0);
                k++;
            end
            res[k-1].flags.last_out = 1'b1;
            filled = 0;
        end

        for (int i = 0; i < k; i++)
            awaited.push_back(res[i]);
    endtask

    // compare one output word with the oldest expectation
    task automatic check_word();
        out_word_t want;
        if (awaited.size() == 0)
        begin
            $display("%0t: unexpected output word %h med=%b last=%b, none expected",
                     $time, m_tdata[SW-1:0], m_tuser, m_tlast);
            errors++;
        end
        else
        begin
            want = awaited.pop_front();
            if (m_tdata[SW-1:0] !== want.smoothed || m_tuser !== want.flags.is_median ||
                m_tlast !== want.flags.last_out)
            begin
                $display("%0t: mismatch, expected %h med=%b last=%b, got %h med=%b last=%b",
                         $time, want.smoothed, want.flags.is_median, want.flags.last_out,
                         m_tdata[SW-1:0], m_tuser, m_tlast);
                errors++;
            end
        end
    endtask

    // watch register writes and both streams
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_cfg = WINDOW_SIZE_RESET;
            filled = 0;
            awaited.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_SIZE)
                ws_cfg = pwdata[WS_W-1:0];
            if (m_tvalid && m_tready)
                check_word();
            if (s_tvalid && s_tready)
                take_sample(s_tdata[SW-1:0], s_tlast);
        end
        n_due = awaited.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import rmf_pkg::*;

    localparam int DW = ((DEF_SAMPLE_BITS + 7) / 8) * 8;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DW-1:0]         s_tdata  = '0;   // sample
    logic                  s_tlast  = 1'b0; // last_of_series
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DW-1:0]         m_tdata;         // smoothed
    logic                  m_tuser;         // is_median
    logic                  m_tlast;         // last_out

    int error_count;
    int words_due;
    int sent_words = 0;
    bit tx_steady  = 1'b0;
    bit rx_steady  = 1'b0;

    running_median_filter_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    rmf_median_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .words_due   (words_due)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // output side: random stall before each word
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            stall = rx_steady ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // one input word with a random gap ahead of it
    task automatic send_sample(input logic [DEF_SAMPLE_BITS-1:0] value, input logic last);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_words++;
    endtask

    // write window_size, upper data bits random
    task automatic set_window(input logic [WS_W-1:0] ws);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_SIZE, 2'b00};
        pwdata  <= ($urandom & ~32'hF) | ws;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop sending, let every expected word arrive, then allow for latency
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    // mix of full-range values, small values with many ties, extremes, and sign-plus-low-byte values
    function automatic logic [DEF_SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 8) - 4;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom & 32'h8000_00FF;
        endcase
    endfunction

    // stimulus and verdict
    initial
    begin
        int len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset window of five, extreme values
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);

        // window of one
        wait_drained();
        set_window(4'd0);
        send_sample(32'd5, 1'b0);
        send_sample(-32'sd5, 1'b0);
        send_sample(32'h8000_0000, 1'b1);

        // widest window, series shorter than it, single-sample series
        wait_drained();
        set_window(4'd15);
        send_sample(32'h1234_5678, 1'b0);
        send_sample(32'hFEDC_BA98, 1'b0);
        send_sample(32'h0000_0010, 1'b1);
        send_sample(32'hA5A5_5A5A, 1'b1);

        // even request rounds up to three, ties in the window
        wait_drained();
        set_window(4'd2);
        send_sample(32'd3, 1'b0);
        send_sample(32'd3, 1'b0);
        send_sample(32'd3, 1'b0);
        send_sample(32'd7, 1'b0);
        send_sample(32'd7, 1'b1);
        send_sample(-32'sd1, 1'b1);

        // random phases: new window, then a few series
        while (sent_words < 320)
        begin
            wait_drained();
            set_window($urandom_range(0, 15));
            repeat ($urandom_range(1, 4))
            begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
                for (int i = 1; i <= len; i++)
                    send_sample(pick_sample(), i == len);
            end
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
        if (error_count == 0 && words_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
